/* sv/sopm_pkg.sv */
package sopm_pkg;

   // Field widths
   localparam int MOD_W      = 16;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_DATA_W = 32;
   localparam int AMP_W      = 16;
   localparam int MAG_W      = 16;

   // Default geometry
   localparam int PHASE_BITS_DEF      = 32;
   localparam int TABLE_ADDR_BITS_DEF = 10;

   // Register reset values
   localparam logic [31:0]      PHASE_STEP_RST = 32'd97391549;
   localparam logic [AMP_W-1:0] AMPLITUDE_RST  = 16'd16384;
   localparam logic [AMP_W-1:0] AMP_FULL_SCALE = 16'h8000;

   // 2^32 / pi, rounded
   localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_AMPLITUDE   = 2'd1,
      CSR_START_PHASE = 2'd2,
      CSR_MOD_ENABLE  = 2'd3
   } csr_index_type;

   // Q30 odd polynomial for sin(pi/2 * u), Horner form in u^2
   localparam logic [31:0] SINE_COEF [7] = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026997,
      32'd172272, 32'd3864, 32'd61
   };

   // Quarter-wave entry idx of a table with 2^addr_bits steps, Q15, capped at 1.0
   function automatic logic [MAG_W-1:0] sine_entry(int unsigned idx, int unsigned addr_bits);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] acc;
      logic [63:0] t;
      logic [63:0] v;
      u   = 64'(idx) << (30 - addr_bits);
      u2  = (u * u) >> 30;
      acc = 64'(SINE_COEF[6]);
      for (int k = 5; k >= 0; k--) begin
         t   = (acc * u2) >> 30;
         acc = (64'(SINE_COEF[k]) > t) ? 64'(SINE_COEF[k]) - t : 64'd0;
      end
      t = (acc * u) >> 30;
      v = (t * 64'd32768 + (64'd1 << 29)) >> 30;
      return (v > 64'd32768) ? AMP_FULL_SCALE : v[MAG_W-1:0];
   endfunction

endpackage

/* sv/sopm_req_if.sv */
interface sopm_req_if;
   import sopm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [MOD_W-1:0] mod_left;
   logic signed [MOD_W-1:0] mod_right;

   modport source (output valid, output mod_left, output mod_right, input ready);
   modport sink   (input valid, input mod_left, input mod_right, output ready);
endinterface

/* sv/sopm_rsp_if.sv */
interface sopm_rsp_if;
   import sopm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* sv/sine_oscillator_phase_mod_core.sv */
// Six register stages: channel sum, modulation offset, modulated phase, table read, multiply, result.
// Throughput: one item per cycle while rsp is ready; the phase accumulator add is the only loop,
//   and the sine table is a ROM with one registered read per item.
// Stages stall independently, so bubbles collapse and items are taken while rsp waits.
// Reset (synchronous, active high): pipeline empty, phase accumulator 0, phase step,
//   amplitude and modulation enable at their default values.
module sine_oscillator_phase_mod_core #(
   parameter int PHASE_BITS      = sopm_pkg::PHASE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = sopm_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sopm_req_if.sink                             req_chan,
   sopm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  sopm_pkg::csr_index_type              csr_index,
   input  logic [sopm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sopm_pkg::*;

   localparam int PB        = PHASE_BITS;
   localparam int TA        = TABLE_ADDR_BITS;
   localparam int ROM_DEPTH = (1 << TA) + 1;
   // Modulation product is 17 x 31 = 48 bits; shift back to phase units
   localparam int MPROD_W   = 48;
   localparam int MOD_SH    = 49 - PB;
   localparam logic [TA:0] ROM_TOP = (TA+1)'(1 << TA);

   // Pipeline stage positions
   localparam int ST_IN  = 0;   // input register, channel sum
   localparam int ST_MOD = 1;   // scaled modulation offset
   localparam int ST_PH  = 2;   // modulated phase, accumulator step
   localparam int ST_ROM = 3;   // table read
   localparam int ST_MUL = 4;   // amplitude multiply
   localparam int ST_OUT = 5;   // saturated sample, result register
   localparam int NSTAGE = 6;

   // Quarter-wave table, built at elaboration, one 16-bit entry per step
   function automatic logic [ROM_DEPTH*MAG_W-1:0] build_rom();
      logic [ROM_DEPTH*MAG_W-1:0] r;
      r = '0;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r[i*MAG_W +: MAG_W] = sine_entry(i, TA);
      end
      return r;
   endfunction

   localparam logic [ROM_DEPTH*MAG_W-1:0] SINE_ROM = build_rom();

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0]      phase_step_ff, phase_step_in;
   logic [AMP_W-1:0] amplitude_ff, amplitude_in;
   logic             mod_enable_ff, mod_enable_in;
   logic [PB-1:0]    acc_ff, acc_in;
   logic             start_wr;

   // 32-bit phase registers aligned to PB bits: (v * 2^PB) >> 32
   function automatic logic [PB-1:0] align_phase(logic [31:0] v);
      logic [PB+31:0] t;
      t = {v, PB'(0)};
      return t[PB+31:32];
   endfunction

   // ------------------------------------------------------------------
   // Handshake: per-stage valid with bubble collapse
   // ------------------------------------------------------------------
   logic [NSTAGE-1:0] valid_ff, valid_in;
   logic [NSTAGE-1:0] load, free, drain;

   always_comb begin
      drain[ST_OUT] = rsp_chan.ready;
      free[ST_OUT]  = !valid_ff[ST_OUT] || drain[ST_OUT];
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         drain[k] = free[k+1];
         free[k]  = !valid_ff[k] || drain[k];
      end
      load[ST_IN] = req_chan.valid && free[ST_IN];
      for (int k = 1; k < NSTAGE; k++) begin
         load[k] = valid_ff[k-1] && free[k];
      end
      for (int k = 0; k < NSTAGE; k++) begin
         valid_in[k] = load[k] || (valid_ff[k] && !drain[k]);
      end
   end

   assign req_chan.ready = free[ST_IN];
   assign rsp_chan.valid = valid_ff[ST_OUT];

   // ------------------------------------------------------------------
   // Stage payloads
   // ------------------------------------------------------------------
   logic signed [MOD_W:0]  sum1_ff, sum1_in;     // l + r, 17 bits
   logic [PB-1:0]          off2_ff, off2_in;     // |offset| in phase units
   logic                   neg2_ff, neg2_in;
   logic [PB-1:0]          ph3_ff, ph3_in;
   logic [MAG_W-1:0]       mag4_ff;
   logic                   neg4_ff;
   logic [MAG_W-1:0]       prod5_ff, prod5_in;
   logic                   neg5_ff;
   logic [SAMPLE_W-1:0]    sample_ff, sample_in;

   logic [MOD_W:0]         sum_abs;
   logic [MPROD_W-1:0]     mprod;
   logic [MPROD_W:0]       mround;
   logic [1:0]             quad;
   logic [TA-1:0]          tab_k;
   logic [TA:0]            rom_addr;
   logic [AMP_W-1:0]       amp_cap;
   logic [31:0]            aprod;

   always_comb begin
      sum1_in = (MOD_W+1)'(req_chan.mod_left) + (MOD_W+1)'(req_chan.mod_right);

      // offset = round(|s| * 2^32/pi / 2^(49-PB)), half away from zero via magnitude
      sum_abs  = sum1_ff[MOD_W] ? (MOD_W+1)'(-sum1_ff) : (MOD_W+1)'(sum1_ff);
      mprod    = MPROD_W'(sum_abs) * MPROD_W'(INV_PI_Q32);
      mround   = {1'b0, mprod} + ((MPROD_W+1)'(1) << (MOD_SH - 1));
      off2_in  = mod_enable_ff ? mround[MPROD_W:MOD_SH] : '0;
      neg2_in  = sum1_ff[MOD_W];

      ph3_in   = neg2_ff ? acc_ff - off2_ff : acc_ff + off2_ff;

      // Odd quadrants read the table mirrored
      quad     = ph3_ff[PB-1 -: 2];
      tab_k    = ph3_ff[PB-3 -: TA];
      rom_addr = quad[0] ? ROM_TOP - {1'b0, tab_k} : {1'b0, tab_k};

      amp_cap  = (amplitude_ff > AMP_FULL_SCALE) ? AMP_FULL_SCALE : amplitude_ff;
      aprod    = 32'(mag4_ff) * 32'(amp_cap) + 32'd16384;
      prod5_in = aprod[MAG_W+14:15];

      // Magnitude is at most full scale: only the positive end saturates
      if (neg5_ff) begin
         sample_in = SAMPLE_W'(-prod5_ff);
      end else if (prod5_ff == AMP_FULL_SCALE) begin
         sample_in = SAMPLE_W'(16'h7FFF);
      end else begin
         sample_in = prod5_ff;
      end
   end

   assign rsp_chan.sample = sample_ff;

   always_ff @(posedge clock) begin
      if (load[ST_IN]) begin
         sum1_ff <= sum1_in;
      end
      if (load[ST_MOD]) begin
         off2_ff <= off2_in;
         neg2_ff <= neg2_in;
      end
      if (load[ST_PH]) begin
         ph3_ff <= ph3_in;
      end
      if (load[ST_ROM]) begin
         mag4_ff <= SINE_ROM[rom_addr*MAG_W +: MAG_W];
         neg4_ff <= quad[1];
      end
      if (load[ST_MUL]) begin
         prod5_ff <= prod5_in;
         neg5_ff  <= neg4_ff;
      end
      if (load[ST_OUT]) begin
         sample_ff <= sample_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration and phase accumulator
   // ------------------------------------------------------------------
   assign start_wr = csr_wr_en && (csr_index == CSR_START_PHASE);

   always_comb begin
      phase_step_in = phase_step_ff;
      amplitude_in  = amplitude_ff;
      mod_enable_in = mod_enable_ff;
      acc_in        = acc_ff;
      if (load[ST_PH]) begin
         acc_in = ph3_in + align_phase(phase_step_ff);
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP:  phase_step_in = csr_wdata[31:0];
            CSR_AMPLITUDE:   amplitude_in  = csr_wdata[AMP_W-1:0];
            CSR_START_PHASE: acc_in        = align_phase(csr_wdata[31:0]);
            CSR_MOD_ENABLE:  mod_enable_in = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         phase_step_ff <= PHASE_STEP_RST;
         amplitude_ff  <= AMPLITUDE_RST;
         mod_enable_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         valid_ff      <= valid_in;
         phase_step_ff <= phase_step_in;
         amplitude_ff  <= amplitude_in;
         mod_enable_ff <= mod_enable_in;
         acc_ff        <= acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      !load[ST_PH] && !start_wr |=> $stable(acc_ff))
      else $error("phase accumulator moved without an item or start phase write");

   a_rom_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_MUL] |-> (mag4_ff <= AMP_FULL_SCALE))
      else $error("table magnitude above full scale");

   a_sign: assert property (@(posedge clock) disable iff (reset)
      load[ST_OUT] |=> (sample_ff == '0) || (sample_ff[SAMPLE_W-1] == $past(neg5_ff)))
      else $error("sample sign does not match quadrant");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff[ST_OUT]) |-> $past(valid_ff[ST_MUL]))
      else $error("result appeared without an item behind it");

endmodule

/* tb/sine_oscillator_phase_mod_core_tb.sv */
`timescale 1ns / 100ps

module sine_oscillator_phase_mod_core_tb;
   import sopm_pkg::*;

   localparam int TAB_BITS        = TABLE_ADDR_BITS_DEF;
   localparam int TAB_N           = 1 << TAB_BITS;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   // pipeline is six stages deep; idle pad covers it with margin
   localparam int DRAIN_PAD       = 8;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   // receiver behavior for one stretch of cycles
   typedef enum logic [1:0] {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE} drain_mode_type;

   // One row of the directed table. A ROW_CSR row writes data to index; a ROW_ITEM row
   // sends left/right. With fixed set, sample is the known answer; otherwise the
   // oscillator model supplies it.
   typedef struct {
      row_kind_type            kind;
      csr_index_type           index;
      logic [31:0]             data;
      logic signed [MOD_W-1:0] left;
      logic signed [MOD_W-1:0] right;
      bit                      fixed;
      logic signed [15:0]      sample;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sopm_req_if req_bus ();
   sopm_rsp_if rsp_bus ();

   sine_oscillator_phase_mod_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Oscillator model: own copy of the registers and the phase accumulator
   // ---------------------------------------------------------------------------
   logic [31:0] osc_phase;
   logic [31:0] osc_step;
   logic [15:0] osc_amp;
   logic        osc_mod_en;
   logic [16:0] quarter_wave [0:TAB_N];

   logic signed [SAMPLE_W-1:0] expected_samples [$];
   int                         error_count = 0;
   int                         cycle_count = 0;

   // receiver state
   logic           sink_ready    = 1'b0;
   drain_mode_type drain_mode    = DRAIN_FULL;
   int             seg_left      = 0;
   int             hold_left     = 0;
   bit             hold_off_go   = 1'b0;
   bit             hold_off_done = 1'b0;

   assign rsp_bus.ready = sink_ready;

   // Quarter-wave entry i: Q30 odd polynomial in Horner form with truncating
   // products, rounded half up to Q15, capped at 1.0.
   function automatic logic [16:0] quarter_wave_entry(int unsigned i);
      logic [63:0] u;
      logic [63:0] u_sq;
      logic [63:0] acc;
      logic [63:0] t;
      logic [63:0] q15;
      u    = 64'(i) << (30 - TAB_BITS);
      u_sq = (u * u) >> 30;
      acc  = 64'(SINE_COEF[6]);
      for (int k = 5; k >= 0; k--) begin
         t   = (acc * u_sq) >> 30;
         acc = (64'(SINE_COEF[k]) > t) ? 64'(SINE_COEF[k]) - t : 64'd0;
      end
      q15 = ((((acc * u) >> 30) * 64'd32768) + (64'd1 << 29)) >> 30;
      return (q15 > 64'd32768) ? 17'd32768 : q15[16:0];
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [31:0] d);
      case (idx)
         CSR_PHASE_STEP:  osc_step   = d;
         CSR_AMPLITUDE:   osc_amp    = d[15:0];
         CSR_START_PHASE: osc_phase  = d;       // loads the accumulator too
         CSR_MOD_ENABLE:  osc_mod_en = d[0];
         default: ;
      endcase
   endfunction

   // Advances the model by one item and returns the sample it yields.
   function automatic logic signed [15:0] predict_sample(logic signed [MOD_W-1:0] l,
                                                          logic signed [MOD_W-1:0] r);
      int          mod_sum;
      logic [63:0] mod_prod;
      logic [63:0] delta;
      logic [1:0]  quad;
      logic [9:0]  idx;
      logic [16:0] mag;
      logic [16:0] amp_eff;
      logic [33:0] scaled;
      int          val;
      if (osc_mod_en) begin
         // (l+r)/2 in 1/32768 rad -> phase: |l+r| * 2^32/pi, >> 17 rounding half away
         mod_sum  = int'(l) + int'(r);
         mod_prod = 64'(mod_sum < 0 ? -mod_sum : mod_sum) * 64'(INV_PI_Q32);
         delta    = (mod_prod + (64'd1 << 16)) >> 17;
         osc_phase = (mod_sum < 0) ? osc_phase - delta[31:0] : osc_phase + delta[31:0];
      end
      quad    = osc_phase[31:30];
      idx     = osc_phase[29:20];
      mag     = quad[0] ? quarter_wave[TAB_N - idx] : quarter_wave[idx];
      amp_eff = (osc_amp > AMP_FULL_SCALE) ? 17'h08000 : {1'b0, osc_amp};
      scaled  = (34'(mag) * 34'(amp_eff) + 34'd16384) >> 15;
      val     = quad[1] ? -int'(scaled) : int'(scaled);
      if (val > 32767)  val = 32767;
      if (val < -32768) val = -32768;
      osc_phase = osc_phase + osc_step;
      return 16'(val);
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table: reset state, full-scale saturation both ways, amplitude
   // above full scale and zero, modulation extremes, large step and wrap.
   // ---------------------------------------------------------------------------
   localparam int NUM_DIRECTED = 33;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      // right after reset: phase 0 gives a zero sample; second item's inputs are ignored
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h7FFF, 16'h8000, 1'b0, 16'h0000},
      // frozen phase at the quadrant edges, full-scale amplitude
      '{ROW_CSR,  CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_AMPLITUDE,   32'h0000_8000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_START_PHASE, 32'h4000_0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h7FFF},
      '{ROW_CSR,  CSR_START_PHASE, 32'hC000_0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h8000},
      // amplitude above full scale acts as full scale
      '{ROW_CSR,  CSR_AMPLITUDE,   32'h0000_FFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h8000},
      '{ROW_CSR,  CSR_AMPLITUDE,   32'h0,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h0000},
      '{ROW_CSR,  CSR_AMPLITUDE,   32'h0000_8000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_START_PHASE, 32'h8000_0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b1, 16'h0000},
      // modulation extremes and alternating bit patterns
      '{ROW_CSR,  CSR_MOD_ENABLE,  32'h1,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h8000, 16'h8000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h7FFF, 16'h8000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'hFFFF, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h5555, 16'hAAAA, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'hAAAA, 16'h5555, 1'b0, 16'h0000},
      // half-turn step, then the largest step (wraps every item)
      '{ROW_CSR,  CSR_PHASE_STEP,  32'h8000_0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_PHASE_STEP,  32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0001, 16'h0001, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'hFFFE, 16'h0003, 1'b0, 16'h0000},
      // accumulator at the top of its range
      '{ROW_CSR,  CSR_START_PHASE, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
      // only bit 0 of the enable counts: this write turns modulation off
      '{ROW_CSR,  CSR_MOD_ENABLE,  32'hFFFF_FFFE, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_ITEM, CSR_PHASE_STEP,  32'h0,         16'h7FFF, 16'h7FFF, 1'b0, 16'h0000}
   };

   // ---------------------------------------------------------------------------
   // Clock and run-time limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge. Stretches of always-ready,
   // coin-flip and mostly-stalled, plus one long hold-off on request so the
   // pipeline fills and pushes back on req.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         sink_ready <= 1'b0;
      end else if (hold_off_go && !hold_off_done) begin
         hold_off_done <= 1'b1;
         hold_left     <= HOLD_OFF_CYCLES;
         sink_ready    <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            drain_mode <= drain_mode_type'($urandom_range(0, 2));
            seg_left   <= $urandom_range(8, 64);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (drain_mode)
            DRAIN_FULL: sink_ready <= 1'b1;
            DRAIN_HALF: sink_ready <= 1'($urandom_range(0, 1));
            default:    sink_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Sample checker: each accepted sample against the oldest expectation.
   always @(posedge clock) begin : check_samples
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: sample %0d with nothing expected", $time, rsp_bus.sample);
            error_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_bus.sample !== want) begin
               $display("%0t: sample mismatch: expected %0d, got %0d",
                        $time, want, rsp_bus.sample);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender tasks. Each is entered just after a falling edge and returns just
   // after one, so valid gets at most one update per time step.
   // ---------------------------------------------------------------------------

   // Offers one item, holds it until taken, then books the expected sample.
   task automatic send_item(logic signed [MOD_W-1:0] l, logic signed [MOD_W-1:0] r,
                            bit fixed, logic signed [15:0] fixed_sample);
      logic signed [15:0] predicted;
      req_bus.valid     <= 1'b1;
      req_bus.mod_left  <= l;
      req_bus.mod_right <= r;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_sample(l, r);
      expected_samples.push_back(fixed ? fixed_sample : predicted);
      @(negedge clock);
   endtask

   task automatic idle_gap(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stop sending and let every sample in flight come out.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      apply_csr(idx, d);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // random modulation value, biased toward the range ends
   function automatic logic signed [MOD_W-1:0] pick_mod();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // first phases pin the extremes, later ones are random
   function automatic logic [31:0] pick_step(int p);
      case (p)
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0;
         default:
            case ($urandom_range(0, 3))
               0:       return $urandom_range(0, 32'h00FF_FFFF);   // audio-ish rates
               1:       return 32'h8000_0000;
               default: return $urandom;
            endcase
      endcase
   endfunction

   function automatic logic [15:0] pick_amp(int p);
      case (p)
         0: return AMP_FULL_SCALE;
         1: return 16'hFFFF;
         2: return 16'h0;
         default:
            case ($urandom_range(0, 3))
               0:       return 16'($urandom_range(32769, 65535));  // above full scale
               default: return 16'($urandom_range(0, 32768));
            endcase
      endcase
   endfunction

   function automatic logic [31:0] pick_start(int p);
      case (p)
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      stim_row_type row;
      int           items_left;
      int           burst_len;
      int           gap_len;
      bit           mod_on;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_PHASE_STEP;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.mod_left  = '0;
      req_bus.mod_right = '0;

      for (int i = 0; i <= TAB_N; i++) quarter_wave[i] = quarter_wave_entry(i);
      osc_step   = PHASE_STEP_RST;
      osc_amp    = AMPLITUDE_RST;
      osc_phase  = 32'h0;
      osc_mod_en = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: registers only change with the pipeline empty
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.index, row.data);
         end else begin
            send_item(row.left, row.right, row.fixed, row.sample);
         end
      end

      // random part: one register setting per phase, items in bursts with gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         // modulation mostly on; phase 0 checks a plain tone, phase 1 forces it on
         mod_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
         write_csr(CSR_PHASE_STEP, pick_step(p));
         write_csr(CSR_AMPLITUDE, {16'($urandom), pick_amp(p)});
         write_csr(CSR_MOD_ENABLE, {31'($urandom), mod_on});
         write_csr(CSR_START_PHASE, pick_start(p));
         if (p == 3) hold_off_go <= 1'b1;   // long receiver stall while we keep sending

         items_left = ITEMS_PER_PHASE;
         while (items_left > 0) begin
            burst_len = $urandom_range(1, 32);
            if (burst_len > items_left) burst_len = items_left;
            repeat (burst_len) send_item(pick_mod(), pick_mod(), 1'b0, 16'h0000);
            items_left -= burst_len;
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0) idle_gap(gap_len);
         end
      end

      wait_idle();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/sopm_pkg.sv
sv/sopm_req_if.sv
sv/sopm_rsp_if.sv
sv/sine_oscillator_phase_mod_core.sv
tb/sine_oscillator_phase_mod_core_tb.sv
